// ===== rtl/srfc_pkg.sv =====
// ----------------------------------------------------------------------------
// srfc_pkg
// types, register indexes and helpers shared by the range follow controller
// ----------------------------------------------------------------------------
package srfc_pkg;

  localparam int unsigned DutyMax      = 100;
  localparam int unsigned GoDistance   = 150;
  localparam logic [8:0]  SweepMinInit = 9'd511;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_SPEED    = 3'd0,
    REG_TURN_BOOST    = 3'd1,
    REG_NEAR_LIMIT    = 3'd2,
    REG_FAR_LIMIT     = 3'd3,
    REG_ANGLE_LIMIT   = 3'd4,
    REG_HEAD_SPEED    = 3'd5,
    REG_SPIN_SPEED    = 3'd6,
    REG_STOP_DISTANCE = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_IN_RANGE  = 2'd0,
    CLS_TOO_FAR   = 2'd1,
    CLS_TOO_CLOSE = 2'd2
  } range_cls_t;

  typedef struct packed {
    logic [6:0]  base_speed;
    logic [6:0]  turn_boost;
    logic [7:0]  near_limit;
    logic [7:0]  far_limit;
    logic [14:0] angle_limit;
    logic [6:0]  head_speed;
    logic [6:0]  spin_speed;
    logic [7:0]  stop_distance;
  } cfg_t;

  typedef struct packed {
    logic [8:0]         sweep_min;
    logic signed [15:0] angle_at_min;
    logic               reversing;
    logic               head_dir_neg;
    logic               touch_prev;
    logic               enable_flag;
    logic signed [7:0]  left_set;
    logic signed [7:0]  right_set;
    logic signed [7:0]  head_set;
    logic               run_flag;
  } ctl_state_t;

  typedef struct packed {
    logic [7:0]         range_cm;
    logic signed [15:0] head_angle;
    logic               touch_level;
  } sample_t;

  typedef struct packed {
    logic signed [7:0] left_duty;
    logic signed [7:0] right_duty;
    logic signed [7:0] head_duty;
    logic              wheels_running;
    logic              enabled;
    range_cls_t        range_class;
  } result_t;

  // saturate a non-negative duty at the upper limit
  function automatic logic signed [7:0] clamp_pos(input logic [7:0] v);
    if (v > 8'(DutyMax)) begin
      return 8'(DutyMax);
    end
    return v;
  endfunction

endpackage

// ===== rtl/srfc_step.sv =====
// ----------------------------------------------------------------------------
// srfc_step
// per-sample update of sweep minimum, head reversal, wheel duties, run flag and enable
// ----------------------------------------------------------------------------
module srfc_step (
  input  srfc_pkg::cfg_t       cfg,
  input  srfc_pkg::ctl_state_t cur,
  input  srfc_pkg::sample_t    smp,
  output srfc_pkg::ctl_state_t nxt,
  output srfc_pkg::result_t    res
);
  import srfc_pkg::*;

  logic [15:0] mag;
  logic [8:0]  min_new;
  logic signed [15:0] amin_new;
  range_cls_t  cls;
  logic        en_new;
  logic        past_limit;
  logic        back_inside;
  logic        head_neg_new;
  logic [7:0]  boosted;
  logic        run_ok;

  assign mag = smp.head_angle[15] ? 16'(-smp.head_angle) : smp.head_angle;
  assign past_limit = mag > {1'b0, cfg.angle_limit};
  assign back_inside = !past_limit && cur.reversing;
  assign boosted = {1'b0, cfg.base_speed} + {1'b0, cfg.turn_boost};
  assign en_new = cur.enable_flag ^ (smp.touch_level && !cur.touch_prev);
  assign head_neg_new = !cur.head_dir_neg;
  assign run_ok = en_new && (smp.range_cm > cfg.stop_distance);

  always_comb begin
    if ({1'b0, smp.range_cm} < cur.sweep_min) begin
      min_new  = {1'b0, smp.range_cm};
      amin_new = smp.head_angle;
    end else begin
      min_new  = cur.sweep_min;
      amin_new = cur.angle_at_min;
    end
  end

  always_comb begin
    priority if (min_new > {1'b0, cfg.far_limit}) begin
      cls = CLS_TOO_FAR;
    end else if (min_new < {1'b0, cfg.near_limit}) begin
      cls = CLS_TOO_CLOSE;
    end else begin
      cls = CLS_IN_RANGE;
    end
  end

  always_comb begin
    nxt              = cur;
    nxt.sweep_min    = min_new;
    nxt.angle_at_min = amin_new;
    nxt.touch_prev   = smp.touch_level;
    nxt.enable_flag  = en_new;

    if (past_limit && !cur.reversing) begin
      nxt.reversing    = 1'b1;
      nxt.head_dir_neg = head_neg_new;
      nxt.head_set     = head_neg_new ? -$signed({1'b0, cfg.head_speed})
                                      : $signed({1'b0, cfg.head_speed});
    end

    // sweep finished: steer by the class of its minimum
    if (back_inside) begin
      unique case (cls)
        CLS_IN_RANGE: begin
          if (amin_new > 16'sd0) begin
            nxt.right_set = clamp_pos({1'b0, cfg.base_speed});
            nxt.left_set  = clamp_pos(boosted);
          end else begin
            nxt.left_set  = clamp_pos({1'b0, cfg.base_speed});
            nxt.right_set = clamp_pos(boosted);
          end
        end
        CLS_TOO_CLOSE: begin
          nxt.left_set  = '0;
          nxt.right_set = '0;
        end
        default: begin
          nxt.right_set = clamp_pos({1'b0, cfg.spin_speed});
          nxt.left_set  = -clamp_pos({1'b0, cfg.spin_speed});
        end
      endcase
      nxt.reversing = 1'b0;
      nxt.sweep_min = SweepMinInit;
    end

    if (run_ok) begin
      if (smp.range_cm < 8'(GoDistance)) begin
        nxt.run_flag = 1'b1;
      end
    end else begin
      nxt.run_flag  = 1'b0;
      nxt.left_set  = '0;
      nxt.right_set = '0;
    end
  end

  always_comb begin
    res.left_duty      = nxt.left_set;
    res.right_duty     = nxt.right_set;
    res.head_duty      = nxt.head_set;
    res.wheels_running = nxt.run_flag;
    res.enabled        = nxt.enable_flag;
    res.range_class    = cls;
  end

endmodule

// ===== rtl/scanning_range_follow_controller.sv =====
// ----------------------------------------------------------------------------
// scanning_range_follow_controller
// follows the nearest object seen by a sweeping range head
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  in_      slave      range sample, head angle, touch level
//  out_     master     wheel and head duties, run, enable, range class
//  cfg_     write      eight setup registers, index 0 to 7
//
//  one sample per cycle while out_tready allows; each sample is captured in the
//  input register and its result is then registered in the output register
//  the throughput limit is the single state update per sample
//  synchronous active-low reset restores register defaults and controller state
//  out_tready low stalls the output register; the input side keeps one sample
// ----------------------------------------------------------------------------
module scanning_range_follow_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // range_cm[7:0], head_angle[23:8], touch_level[24], zero [31:25]
  input  logic [srfc_pkg::InDataW-1:0]    in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // left_duty[7:0], right_duty[15:8], head_duty[23:16], wheels_running[24],
  // enabled[25], range_class[27:26], zero [31:28]
  output logic [srfc_pkg::OutDataW-1:0]   out_tdata,
  input  logic                            cfg_we,
  input  logic [srfc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [srfc_pkg::CfgDataW-1:0]   cfg_wdata
);
  import srfc_pkg::*;

  cfg_t       cfg_r;
  ctl_state_t st_r;
  ctl_state_t st_nxt;
  sample_t    smp_r;
  logic       smp_valid_r;
  result_t    res_nxt;
  result_t    res_r;
  logic       out_valid_r;
  logic       step_go;

  assign step_go   = smp_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !smp_valid_r || step_go;

  srfc_step u_step (
    .cfg (cfg_r),
    .cur (st_r),
    .smp (smp_r),
    .nxt (st_nxt),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed    <= 7'd30;
      cfg_r.turn_boost    <= 7'd40;
      cfg_r.near_limit    <= 8'd10;
      cfg_r.far_limit     <= 8'd200;
      cfg_r.angle_limit   <= 15'd90;
      cfg_r.head_speed    <= 7'd50;
      cfg_r.spin_speed    <= 7'd70;
      cfg_r.stop_distance <= 8'd20;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BASE_SPEED:    cfg_r.base_speed    <= cfg_wdata[6:0];
        REG_TURN_BOOST:    cfg_r.turn_boost    <= cfg_wdata[6:0];
        REG_NEAR_LIMIT:    cfg_r.near_limit    <= cfg_wdata[7:0];
        REG_FAR_LIMIT:     cfg_r.far_limit     <= cfg_wdata[7:0];
        REG_ANGLE_LIMIT:   cfg_r.angle_limit   <= cfg_wdata[14:0];
        REG_HEAD_SPEED:    cfg_r.head_speed    <= cfg_wdata[6:0];
        REG_SPIN_SPEED:    cfg_r.spin_speed    <= cfg_wdata[6:0];
        REG_STOP_DISTANCE: cfg_r.stop_distance <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.sweep_min    <= SweepMinInit;
      st_r.angle_at_min <= '0;
      st_r.reversing    <= 1'b0;
      st_r.head_dir_neg <= 1'b0;
      st_r.touch_prev   <= 1'b0;
      st_r.enable_flag  <= 1'b0;
      st_r.left_set     <= 8'sd30;
      st_r.right_set    <= 8'sd30;
      st_r.head_set     <= 8'sd50;
      st_r.run_flag     <= 1'b0;
    end else if (step_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        smp_valid_r <= in_tvalid;
      end
      if (step_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      smp_r.range_cm    <= in_tdata[7:0];
      smp_r.head_angle  <= in_tdata[23:8];
      smp_r.touch_level <= in_tdata[24];
    end
    if (step_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.range_class, res_r.enabled, res_r.wheels_running,
                       res_r.head_duty, res_r.right_duty, res_r.left_duty};

endmodule

// ===== rtl/srfc_checker.sv =====
// ----------------------------------------------------------------------------
// srfc_checker
// port-level checks for the range follow controller
// ----------------------------------------------------------------------------
module srfc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [srfc_pkg::OutDataW-1:0] out_tdata
);
  import srfc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // wheels never run while disabled
  a_run_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[24] || out_tdata[25]))
    else $error("wheels running while disabled");

  // disabled means both wheel duties are zero
  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[25] |-> out_tdata[15:0] == 16'h0000)
    else $error("wheel duty nonzero while disabled");

endmodule

bind scanning_range_follow_controller srfc_checker u_srfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/scanning_range_follow_controller_tb.sv =====
// ----------------------------------------------------------------------------
// scanning_range_follow_controller_tb
// drives range, head angle and touch requests into the follow controller and
// checks untyped setpoint results against a cycle-free behavioral predictor;
// a directed table of corner cases comes first, then sweep-shaped random
// traffic over several register settings, most with random stalls on both sides
// ----------------------------------------------------------------------------
module scanning_range_follow_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srfc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int          ChunkItems = 100;
  localparam int          Chunks     = 7;

  // predictor state for one controller
  typedef struct {
    int nearest;
    int nearest_ang;
    bit turning;
    bit head_neg;
    bit touch_last;
    bit en;
    int left;
    int right;
    int head;
    bit run;
  } tracker_t;

  typedef struct {
    logic [7:0]         rng;
    logic signed [15:0] ang;
    logic               tch;
    bit                 typed;
    result_t            res;
  } row_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_wdata  = '0;

  tracker_t    trk;
  cfg_t        setup;
  result_t     setpoint_q[$];
  result_t     got;
  result_t     want;
  int          err_count    = 0;
  int          results_seen = 0;
  int          send_idle    = 0;
  int          recv_idle    = 0;
  bit          stall_done   = 1'b0;
  int unsigned cycle_count  = 0;

  // corner cases under reset settings; typed rows carry a hand-read result
  row_t plan [24] = '{
    '{8'd0,   16'sd0,      1'b0, 1'b1, '{8'sd0, 8'sd0, 8'sd50, 1'b0, 1'b0, CLS_TOO_CLOSE}},
    '{8'd255, 16'sd32767,  1'b1, 1'b1, '{8'sd0, 8'sd0, -8'sd50, 1'b0, 1'b1, CLS_TOO_CLOSE}},
    '{8'd100, -16'sd32768, 1'b1, 1'b1, '{8'sd0, 8'sd0, -8'sd50, 1'b1, 1'b1, CLS_TOO_CLOSE}},
    '{8'd100, 16'sd5,      1'b0, 1'b1, '{8'sd0, 8'sd0, -8'sd50, 1'b1, 1'b1, CLS_TOO_CLOSE}},
    '{8'd120, 16'sd40,     1'b0, 1'b0, '0},
    '{8'd130, 16'sd91,     1'b0, 1'b0, '0},
    '{8'd140, 16'sd90,     1'b0, 1'b0, '0},
    '{8'd60,  -16'sd30,    1'b0, 1'b0, '0},
    '{8'd60,  -16'sd100,   1'b0, 1'b0, '0},
    '{8'd60,  -16'sd90,    1'b0, 1'b0, '0},
    '{8'd210, 16'sd0,      1'b0, 1'b0, '0},
    '{8'd220, 16'sd200,    1'b0, 1'b0, '0},
    '{8'd220, -16'sd1,     1'b0, 1'b0, '0},
    '{8'd20,  16'sd0,      1'b0, 1'b1, '{8'sd0, 8'sd0, 8'sd50, 1'b0, 1'b1, CLS_IN_RANGE}},
    '{8'd21,  16'sd0,      1'b0, 1'b0, '0},
    '{8'd149, 16'sd0,      1'b0, 1'b0, '0},
    '{8'd150, 16'sd0,      1'b1, 1'b0, '0},
    '{8'd150, 16'sd0,      1'b0, 1'b0, '0},
    '{8'd50,  16'sd0,      1'b1, 1'b0, '0},
    '{8'd9,   16'sd10,     1'b0, 1'b0, '0},
    '{8'd30,  16'sd95,     1'b0, 1'b0, '0},
    '{8'd30,  16'sd0,      1'b0, 1'b0, '0},
    '{8'd10,  16'sd0,      1'b0, 1'b0, '0},
    '{8'd200, -16'sd32768, 1'b0, 1'b0, '0}
  };

  scanning_range_follow_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int sat100(input int v);
    if (v > int'(DutyMax)) return int'(DutyMax);
    if (v < -int'(DutyMax)) return -int'(DutyMax);
    return v;
  endfunction

  // one sensor tick of the controller, returns the setpoints after the update
  function automatic result_t follow_step(input logic [7:0] rng, input logic signed [15:0] ang,
                                          input logic tch);
    int         a;
    int         mag;
    int         b;
    int         boosted;
    range_cls_t cls;
    result_t    r;
    a   = int'(ang);
    mag = (a < 0) ? -a : a;
    if (int'(rng) < trk.nearest) begin
      trk.nearest     = int'(rng);
      trk.nearest_ang = a;
    end
    if (trk.nearest > int'(setup.far_limit)) cls = CLS_TOO_FAR;
    else if (trk.nearest < int'(setup.near_limit)) cls = CLS_TOO_CLOSE;
    else cls = CLS_IN_RANGE;
    if (tch && !trk.touch_last) trk.en = !trk.en;
    trk.touch_last = tch;
    if (mag > int'(setup.angle_limit) && !trk.turning) begin
      trk.turning  = 1'b1;
      trk.head_neg = !trk.head_neg;
      trk.head     = trk.head_neg ? -int'(setup.head_speed) : int'(setup.head_speed);
    end
    if (mag <= int'(setup.angle_limit) && trk.turning) begin
      b       = int'(setup.base_speed);
      boosted = b + int'(setup.turn_boost);
      case (cls)
        CLS_IN_RANGE: begin
          // outer wheel is on the side where the nearest object was seen
          if (trk.nearest_ang > 0) begin
            trk.right = sat100(b);
            trk.left  = sat100(boosted);
          end else begin
            trk.left  = sat100(b);
            trk.right = sat100(boosted);
          end
        end
        CLS_TOO_CLOSE: begin
          trk.left  = 0;
          trk.right = 0;
        end
        default: begin
          trk.right = sat100(int'(setup.spin_speed));
          trk.left  = sat100(-int'(setup.spin_speed));
        end
      endcase
      trk.turning = 1'b0;
      trk.nearest = int'(SweepMinInit);
    end
    if (trk.en && int'(rng) > int'(setup.stop_distance)) begin
      // beyond the go distance the previous run state is held
      if (int'(rng) < int'(GoDistance)) trk.run = 1'b1;
    end else begin
      trk.run   = 1'b0;
      trk.left  = 0;
      trk.right = 0;
    end
    r.left_duty      = 8'(trk.left);
    r.right_duty     = 8'(trk.right);
    r.head_duty      = 8'(trk.head);
    r.wheels_running = trk.run;
    r.enabled        = trk.en;
    r.range_class    = cls;
    return r;
  endfunction

  // offer one request, wait for acceptance, then queue the expected setpoints
  task automatic offer(input logic [7:0] rng, input logic signed [15:0] ang, input logic tch,
                       input bit typed, input result_t res);
    result_t pred;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, tch, ang, rng};
    do @(posedge clk); while (!in_tready);
    pred = follow_step(rng, ang, tch);
    setpoint_q.push_back(typed ? res : pred);
  endtask

  task automatic load_setup(input cfg_t c);
    logic [14:0] junk;
    logic [14:0] wd;
    reg_idx_t    idx;
    for (int i = 0; i < 8; i++) begin
      idx  = reg_idx_t'(i);
      junk = 15'($urandom);
      // bits above the register width are junk and must be dropped
      case (idx)
        REG_BASE_SPEED:    wd = {junk[14:7], c.base_speed};
        REG_TURN_BOOST:    wd = {junk[14:7], c.turn_boost};
        REG_NEAR_LIMIT:    wd = {junk[14:8], c.near_limit};
        REG_FAR_LIMIT:     wd = {junk[14:8], c.far_limit};
        REG_ANGLE_LIMIT:   wd = c.angle_limit;
        REG_HEAD_SPEED:    wd = {junk[14:7], c.head_speed};
        REG_SPIN_SPEED:    wd = {junk[14:7], c.spin_speed};
        default:           wd = {junk[14:8], c.stop_distance};
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= wd;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    setup = c;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (setpoint_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side: random stalls plus one long hold-off so the input backs up
  initial begin
    forever begin
      @(posedge clk);
      if (!stall_done && results_seen >= 120) begin
        stall_done = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tdata[24], out_tdata[25],
             out_tdata[27:26]};
      results_seen++;
      if (setpoint_q.size() == 0) begin
        err_count++;
        $display("%0t unexpected result: L=%0d R=%0d H=%0d run=%0b en=%0b cls=%0d", $time,
                 got.left_duty, got.right_duty, got.head_duty, got.wheels_running,
                 got.enabled, got.range_class);
      end else begin
        want = setpoint_q.pop_front();
        if (got !== want) begin
          err_count++;
          $display("%0t mismatch: expected %h, actual %h", $time, want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int                 head_pos;
    int                 head_dir;
    int                 step;
    int                 bound;
    int                 r;
    int                 pick;
    logic [7:0]         rng;
    logic signed [15:0] ang;
    logic               tl;
    cfg_t               c;

    trk   = '{int'(SweepMinInit), 0, 1'b0, 1'b0, 1'b0, 1'b0, 30, 30, 50, 1'b0};
    setup = '{base_speed: 30, turn_boost: 40, near_limit: 10, far_limit: 200,
              angle_limit: 90, head_speed: 50, spin_speed: 70, stop_distance: 20};
    send_idle = 25;
    recv_idle = 67;
    tl        = 1'b0;

    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) offer(plan[i].rng, plan[i].ang, plan[i].tch, plan[i].typed, plan[i].res);

    for (int ch = 0; ch < Chunks; ch++) begin
      drain();
      if (ch < 2) begin
        send_idle = 25;
        recv_idle = 67;
      end else if (ch < 4) begin
        send_idle = 67;
        recv_idle = 25;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (ch)
        0: c = '{base_speed: 45, turn_boost: 60, near_limit: 40, far_limit: 120,
                 angle_limit: 60, head_speed: 100, spin_speed: 100, stop_distance: 25};
        1: c = '0;
        2: c = '{base_speed: 127, turn_boost: 127, near_limit: 255, far_limit: 255,
                 angle_limit: 32767, head_speed: 127, spin_speed: 127, stop_distance: 255};
        default: begin
          c.base_speed    = 7'($urandom);
          c.turn_boost    = 7'($urandom);
          c.near_limit    = 8'($urandom_range(0, 120));
          c.far_limit     = 8'($urandom_range(100, 255));
          c.angle_limit   = ($urandom_range(0, 4) == 0) ? 15'($urandom)
                                                        : 15'($urandom_range(5, 300));
          c.head_speed    = 7'($urandom);
          c.spin_speed    = 7'($urandom);
          c.stop_distance = 8'($urandom_range(0, 60));
        end
      endcase
      load_setup(c);
      head_pos = 0;
      head_dir = 1;

      for (int n = 0; n < ChunkItems; n++) begin
        if (ch == 4 && n == ChunkItems / 2) begin
          // sender holds back until every queued result has come out
          in_tvalid <= 1'b0;
          while (setpoint_q.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        if ($urandom_range(0, 9) == 0) begin
          ang = 16'($urandom);
          rng = 8'($urandom);
          tl  = 1'($urandom);
        end else begin
          // head sweeps a little past the angle limit on both sides
          step     = int'(setup.angle_limit) / 6 + 1 + $urandom_range(0, 3);
          bound    = int'(setup.angle_limit) + 2 * step;
          head_pos = head_pos + head_dir * step;
          if (head_pos > 32767) head_pos = 32767;
          if (head_pos < -32768) head_pos = -32768;
          if (head_pos >= bound || head_pos == 32767) head_dir = -1;
          else if (head_pos <= -bound || head_pos == -32768) head_dir = 1;
          ang  = 16'(head_pos);
          pick = $urandom_range(0, 9);
          case (pick)
            0, 1:    r = int'(setup.near_limit) + $urandom_range(0, 4) - 2;
            2, 3:    r = int'(setup.far_limit) + $urandom_range(0, 4) - 2;
            4:       r = int'(setup.stop_distance) + $urandom_range(0, 2) - 1;
            5:       r = int'(GoDistance) + $urandom_range(0, 3) - 2;
            default: r = $urandom_range(0, 255);
          endcase
          if (r < 0) r = 0;
          if (r > 255) r = 255;
          rng = 8'(r);
          // keep the controller enabled most of the time
          if (!trk.en && !tl && $urandom_range(0, 3) == 0) tl = 1'b1;
          else if ($urandom_range(0, 19) == 0) tl = ~tl;
        end
        offer(rng, ang, tl, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (setpoint_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0 && setpoint_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
